// ===== hdl/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

    localparam int LEVEL_W        = 8;
    localparam int HUE_W          = 9;
    localparam int POS_W          = 6;
    localparam int PROD_W         = 14;
    localparam int RECIP_W        = 15;
    localparam int SCALED_W       = PROD_W + RECIP_W;
    localparam int RECIP_SHIFT    = 20;

    localparam logic [POS_W-1:0]   SECTOR_DEGREES = POS_W'(60);
    localparam logic [LEVEL_W-1:0] FULL_LEVEL     = LEVEL_W'(255);
    localparam logic [RECIP_W-1:0] RECIP_60       =
        RECIP_W'(((1 << RECIP_SHIFT) + 59) / 60);

    typedef enum logic [2:0] {
        SEC_0    = 3'd0,
        SEC_1    = 3'd1,
        SEC_2    = 3'd2,
        SEC_3    = 3'd3,
        SEC_4    = 3'd4,
        SEC_5    = 3'd5,
        SEC_NONE = 3'd6
    } sector_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue_degrees;
        logic [LEVEL_W-1:0] saturation;
        logic [LEVEL_W-1:0] brightness;
    } hsv_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_duty;
        logic [LEVEL_W-1:0] green_duty;
        logic [LEVEL_W-1:0] blue_duty;
    } rgb_out_t;

    typedef struct packed {
        sector_t            sector;
        logic [POS_W-1:0]   pos;
        logic               grey;
        logic [LEVEL_W-1:0] val;
        logic [LEVEL_W-1:0] base;
    } sect_stage_t;

    typedef struct packed {
        sector_t            sector;
        logic               grey;
        logic [LEVEL_W-1:0] val;
        logic [LEVEL_W-1:0] base;
        logic [PROD_W-1:0]  prod;
    } scale_stage_t;

    typedef struct packed {
        sector_t             sector;
        logic                grey;
        logic [LEVEL_W-1:0]  val;
        logic [LEVEL_W-1:0]  base;
        logic [SCALED_W-1:0] scaled;
    } div_stage_t;

endpackage

// ===== hdl/hsv_to_rgb_led_drive_core.sv =====
// HSV to RGB converter with active-low LED PWM duty outputs.
// Each item on the s_ channel carries a hue in degrees, a saturation and a
// brightness; each item on the m_ channel carries the red, green and blue
// duties, each 255 minus the channel level. Zero saturation gives grey, and a
// hue of 360 or above with nonzero saturation turns every LED off.
// Both channels use valid and ready; an item moves on a cycle where both are
// high. The block takes one item per cycle with no gaps while m_ready is high.
// From acceptance to m_valid an item passes four registered stages: hue sector
// and base level, ramp multiply, reciprocal multiply for the division by 60,
// and the channel select into the output register.
// A stage advances whenever the stage after it is empty or advancing, so when
// the receiver holds m_ready low the pipeline fills up and s_ready drops only
// once all four stages hold an item; no item is lost or repeated.
// A synchronous active-low reset empties the pipeline; the first item can be
// taken in the cycle after reset is released.
module hsv_to_rgb_led_drive_core
    import hsvrgb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hsv_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rgb_out_t m_data
);

    logic         en1;
    logic         en2;
    logic         en3;
    logic         en4;
    logic         v1;
    logic         v2;
    logic         v3;
    sect_stage_t  st1;
    scale_stage_t st2;
    div_stage_t   st3;

    assign en4     = !m_valid || m_ready;
    assign en3     = !v3 || en4;
    assign en2     = !v2 || en3;
    assign en1     = !v1 || en2;
    assign s_ready = en1;

    hsvrgb_sector u_sector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (en1),
        .in_valid  (s_valid),
        .in_item   (s_data),
        .out_valid (v1),
        .out_stage (st1)
    );

    hsvrgb_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (en2),
        .in_valid  (v1),
        .in_stage  (st1),
        .out_valid (v2),
        .out_stage (st2)
    );

    hsvrgb_div60 u_div60 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (en3),
        .in_valid  (v2),
        .in_stage  (st2),
        .out_valid (v3),
        .out_stage (st3)
    );

    hsvrgb_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (en4),
        .in_valid  (v3),
        .in_stage  (st3),
        .out_valid (m_valid),
        .out_item  (m_data)
    );

    // The input side only stalls when every stage is full behind a stalled output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && v1 && v2 && v3))
        else $error("input stalled while the pipeline has room");

    // The scaled ramp never exceeds the span between base level and brightness.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3 && !st3.grey) |->
            (st3.scaled[SCALED_W-1:RECIP_SHIFT] <= {1'b0, st3.val - st3.base}))
        else $error("ramp quotient out of range");

    // A held item in the divide stage keeps its contents while blocked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3 && !en3) |=> (v3 && $stable(st3)))
        else $error("stalled item changed in divide stage");

endmodule

// ===== hdl/hsvrgb_sector.sv =====
module hsvrgb_sector
    import hsvrgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        enable,
    input  logic        in_valid,
    input  hsv_in_t     in_item,
    output logic        out_valid,
    output sect_stage_t out_stage
);

    logic        valid_reg;
    sect_stage_t stage_reg;
    sect_stage_t stage_next;
    logic [2*LEVEL_W-1:0] base_prod;

    always_comb begin
        base_prod = (2*LEVEL_W)'(FULL_LEVEL - in_item.saturation)
                  * (2*LEVEL_W)'(in_item.brightness);
        stage_next.grey = (in_item.saturation == '0);
        stage_next.val  = in_item.brightness;
        stage_next.base = base_prod[2*LEVEL_W-1:LEVEL_W];
        priority if (in_item.hue_degrees < HUE_W'(60)) begin
            stage_next.sector = SEC_0;
            stage_next.pos    = POS_W'(in_item.hue_degrees);
        end else if (in_item.hue_degrees < HUE_W'(120)) begin
            stage_next.sector = SEC_1;
            stage_next.pos    = POS_W'(in_item.hue_degrees - HUE_W'(60));
        end else if (in_item.hue_degrees < HUE_W'(180)) begin
            stage_next.sector = SEC_2;
            stage_next.pos    = POS_W'(in_item.hue_degrees - HUE_W'(120));
        end else if (in_item.hue_degrees < HUE_W'(240)) begin
            stage_next.sector = SEC_3;
            stage_next.pos    = POS_W'(in_item.hue_degrees - HUE_W'(180));
        end else if (in_item.hue_degrees < HUE_W'(300)) begin
            stage_next.sector = SEC_4;
            stage_next.pos    = POS_W'(in_item.hue_degrees - HUE_W'(240));
        end else if (in_item.hue_degrees < HUE_W'(360)) begin
            stage_next.sector = SEC_5;
            stage_next.pos    = POS_W'(in_item.hue_degrees - HUE_W'(300));
        end else begin
            stage_next.sector = SEC_NONE;
            stage_next.pos    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (enable) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== hdl/hsvrgb_scale.sv =====
module hsvrgb_scale
    import hsvrgb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         enable,
    input  logic         in_valid,
    input  sect_stage_t  in_stage,
    output logic         out_valid,
    output scale_stage_t out_stage
);

    logic               valid_reg;
    scale_stage_t       stage_reg;
    scale_stage_t       stage_next;
    logic [LEVEL_W-1:0] diff;
    logic [POS_W-1:0]   weight;

    always_comb begin
        diff = in_stage.val - in_stage.base;
        unique case (in_stage.sector)
            SEC_1, SEC_3, SEC_5: begin
                weight = SECTOR_DEGREES - in_stage.pos;
            end
            default: begin
                weight = in_stage.pos;
            end
        endcase
        stage_next.sector = in_stage.sector;
        stage_next.grey   = in_stage.grey;
        stage_next.val    = in_stage.val;
        stage_next.base   = in_stage.base;
        stage_next.prod   = PROD_W'(diff) * PROD_W'(weight);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (enable) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== hdl/hsvrgb_div60.sv =====
module hsvrgb_div60
    import hsvrgb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         enable,
    input  logic         in_valid,
    input  scale_stage_t in_stage,
    output logic         out_valid,
    output div_stage_t   out_stage
);

    logic       valid_reg;
    div_stage_t stage_reg;
    div_stage_t stage_next;

    // Division by 60 is a multiply by a rounded-up reciprocal; the error stays
    // below one sixtieth over the whole product range, so the floor is exact.
    always_comb begin
        stage_next.sector = in_stage.sector;
        stage_next.grey   = in_stage.grey;
        stage_next.val    = in_stage.val;
        stage_next.base   = in_stage.base;
        stage_next.scaled = SCALED_W'(in_stage.prod) * SCALED_W'(RECIP_60);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (enable) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== hdl/hsvrgb_mix.sv =====
module hsvrgb_mix
    import hsvrgb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       enable,
    input  logic       in_valid,
    input  div_stage_t in_stage,
    output logic       out_valid,
    output rgb_out_t   out_item
);

    logic               valid_reg;
    rgb_out_t           item_reg;
    rgb_out_t           item_next;
    logic [LEVEL_W-1:0] ramp;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;

    always_comb begin
        ramp = in_stage.base + in_stage.scaled[RECIP_SHIFT +: LEVEL_W];
        red   = '0;
        green = '0;
        blue  = '0;
        if (in_stage.grey) begin
            red   = in_stage.val;
            green = in_stage.val;
            blue  = in_stage.val;
        end else begin
            unique case (in_stage.sector)
                SEC_0: begin
                    red = in_stage.val; green = ramp; blue = in_stage.base;
                end
                SEC_1: begin
                    red = ramp; green = in_stage.val; blue = in_stage.base;
                end
                SEC_2: begin
                    red = in_stage.base; green = in_stage.val; blue = ramp;
                end
                SEC_3: begin
                    red = in_stage.base; green = ramp; blue = in_stage.val;
                end
                SEC_4: begin
                    red = ramp; green = in_stage.base; blue = in_stage.val;
                end
                SEC_5: begin
                    red = in_stage.val; green = in_stage.base; blue = ramp;
                end
                default: begin
                    red = '0; green = '0; blue = '0;
                end
            endcase
        end
        item_next.red_duty   = FULL_LEVEL - red;
        item_next.green_duty = FULL_LEVEL - green;
        item_next.blue_duty  = FULL_LEVEL - blue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (enable) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
